@@ rtl/bpa_pkg.sv @@
package bpa_pkg;

  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  localparam int REQ_W    = 2;
  localparam int PAGE_W   = 10;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 11;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL         = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ALREADY_FREE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE        = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

@@ rtl/bpa_ram.sv @@
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bitmap_page_allocator.sv @@
// channel | signals                                           | direction
// --------+---------------------------------------------------+----------
// in      | in_valid, in_stall, req_type, page_index           | into block
// out     | out_valid, out_stall, status, result_index,        | from block
//         | is_free, pages_in_use                              |
//
// One request at a time. Free and query pass through READ and DONE before the
// next accept; allocate passes through READ, and through SCAN for each bitmap
// word read past the hint's word (up to WORDS-1) while it hunts for the next
// free page, then DONE. Rejected requests go straight to DONE. The bitmap sits
// in one 32-bit-wide RAM with one read port. After reset a clearing pass zeroes
// the RAM word by word (WORDS is 32 by default), with in_stall high. A new
// transaction is taken while a result still waits on out_stall; it then holds in its last state until the output frees.
module bitmap_page_allocator #(
  parameter int NUM_PAGES = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bpa_pkg::REQ_W-1:0]        req_type,
  input  logic [bpa_pkg::PAGE_W-1:0]       page_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bpa_pkg::STATUS_W-1:0]     status,
  output logic [bpa_pkg::PAGE_W-1:0]       result_index,
  output logic                             is_free,
  output logic [bpa_pkg::USED_W-1:0]       pages_in_use
);

  localparam int WORDS     = (NUM_PAGES + bpa_pkg::WORD_W - 1) / bpa_pkg::WORD_W;
  localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW        = $clog2(NUM_PAGES + 1);
  localparam int HW        = (PW > bpa_pkg::USED_W) ? PW : bpa_pkg::USED_W;
  localparam int LAST_BITS = NUM_PAGES - (WORDS - 1) * bpa_pkg::WORD_W;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam logic [HW-1:0] LIMIT     = HW'(NUM_PAGES);
  // bits past the last page in the last word count as used for the scan
  localparam logic [bpa_pkg::WORD_W-1:0] TAIL_PAD =
    (LAST_BITS == bpa_pkg::WORD_W) ? '0 :
    ~((bpa_pkg::WORD_W'(1) << LAST_BITS) - bpa_pkg::WORD_W'(1));

  bpa_pkg::state_t state, state_next;

  logic [HW-1:0]                   hint, hint_next;
  logic [HW-1:0]                   count, count_next;
  logic [AW-1:0]                   clr_addr, clr_addr_next;
  logic [AW-1:0]                   scan_addr, scan_addr_next;
  logic [AW-1:0]                   cur_word, cur_word_next;
  logic [bpa_pkg::BIT_W-1:0]       cur_bit, cur_bit_next;
  logic [bpa_pkg::PAGE_W-1:0]      cur_page, cur_page_next;
  logic [bpa_pkg::REQ_W-1:0]       cur_req, cur_req_next;
  logic [bpa_pkg::STATUS_W-1:0]    res_status, res_status_next;
  logic [bpa_pkg::PAGE_W-1:0]      res_index, res_index_next;
  logic                            res_free, res_free_next;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr, ram_raddr;
  logic [bpa_pkg::WORD_W-1:0]      ram_wdata, ram_rdata;

  logic [bpa_pkg::WORD_W-1:0]      low_mask, probe, bit_mask;
  logic [AW-1:0]                   probe_addr;
  logic                            fz_found;
  logic [bpa_pkg::BIT_W-1:0]       fz_idx;
  logic                            in_accept, out_load;

  bpa_ram #(
    .WIDTH (bpa_pkg::WORD_W),
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state != bpa_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // lowest free page in the word on the read port; in ST_READ only bits above the start bit count
  always_comb begin
    bit_mask   = bpa_pkg::WORD_W'(1) << cur_bit;
    low_mask   = {bpa_pkg::WORD_W{1'b1}} >> (bpa_pkg::BIT_W'(bpa_pkg::WORD_W - 1) - cur_bit);
    probe_addr = (state == bpa_pkg::ST_SCAN) ? scan_addr : cur_word;
    probe      = ram_rdata
               | ((state == bpa_pkg::ST_READ) ? low_mask : '0)
               | ((probe_addr == LAST_WORD) ? TAIL_PAD : '0);
    fz_found   = 1'b0;
    fz_idx     = '0;
    for (int i = bpa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!probe[i]) begin
        fz_found = 1'b1;
        fz_idx   = bpa_pkg::BIT_W'(i);
      end
    end
  end

  always_comb begin
    state_next      = state;
    hint_next       = hint;
    count_next      = count;
    clr_addr_next   = clr_addr;
    scan_addr_next  = scan_addr;
    cur_word_next   = cur_word;
    cur_bit_next    = cur_bit;
    cur_page_next   = cur_page;
    cur_req_next    = cur_req;
    res_status_next = res_status;
    res_index_next  = res_index;
    res_free_next   = res_free;
    ram_we          = 1'b0;
    ram_waddr       = cur_word;
    ram_wdata       = '0;
    ram_raddr       = cur_word;
    out_load        = 1'b0;

    case (state)
      bpa_pkg::ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == LAST_WORD) begin
          state_next = bpa_pkg::ST_IDLE;
        end
      end

      bpa_pkg::ST_IDLE: begin
        if (in_accept) begin
          cur_req_next    = req_type;
          cur_page_next   = page_index;
          res_status_next = bpa_pkg::STATUS_OK;
          res_index_next  = '0;
          res_free_next   = 1'b0;
          state_next      = bpa_pkg::ST_DONE;
          case (req_type)
            bpa_pkg::REQ_ALLOC: begin
              if (hint >= LIMIT) begin
                res_status_next = bpa_pkg::STATUS_FULL;
              end else begin
                res_index_next = hint[bpa_pkg::PAGE_W-1:0];
                cur_word_next  = AW'(hint >> bpa_pkg::BIT_W);
                cur_bit_next   = hint[bpa_pkg::BIT_W-1:0];
                ram_raddr      = AW'(hint >> bpa_pkg::BIT_W);
                state_next     = bpa_pkg::ST_READ;
              end
            end
            bpa_pkg::REQ_FREE, bpa_pkg::REQ_QUERY: begin
              if (HW'(page_index) >= LIMIT) begin
                res_status_next = bpa_pkg::STATUS_RANGE;
              end else begin
                cur_word_next = AW'(page_index >> bpa_pkg::BIT_W);
                cur_bit_next  = page_index[bpa_pkg::BIT_W-1:0];
                ram_raddr     = AW'(page_index >> bpa_pkg::BIT_W);
                state_next    = bpa_pkg::ST_READ;
              end
            end
            default: ;
          endcase
        end
      end

      bpa_pkg::ST_READ: begin
        state_next = bpa_pkg::ST_DONE;
        case (cur_req)
          bpa_pkg::REQ_ALLOC: begin
            ram_we     = 1'b1;
            ram_wdata  = ram_rdata | bit_mask;
            count_next = count + HW'(1);
            if (fz_found) begin
              hint_next = HW'({cur_word, fz_idx});
            end else if (cur_word == LAST_WORD) begin
              hint_next = LIMIT;
            end else begin
              ram_raddr      = cur_word + AW'(1);
              scan_addr_next = cur_word + AW'(1);
              state_next     = bpa_pkg::ST_SCAN;
            end
          end
          bpa_pkg::REQ_FREE: begin
            if (!ram_rdata[cur_bit]) begin
              res_status_next = bpa_pkg::STATUS_ALREADY_FREE;
            end else begin
              ram_we     = 1'b1;
              ram_wdata  = ram_rdata & ~bit_mask;
              count_next = count - HW'(1);
              if (hint > HW'(cur_page)) begin
                hint_next = HW'(cur_page);
              end
            end
          end
          default: begin
            res_free_next = !ram_rdata[cur_bit];
          end
        endcase
      end

      bpa_pkg::ST_SCAN: begin
        if (fz_found) begin
          hint_next  = HW'({scan_addr, fz_idx});
          state_next = bpa_pkg::ST_DONE;
        end else if (scan_addr == LAST_WORD) begin
          hint_next  = LIMIT;
          state_next = bpa_pkg::ST_DONE;
        end else begin
          ram_raddr      = scan_addr + AW'(1);
          scan_addr_next = scan_addr + AW'(1);
        end
      end

      bpa_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = bpa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = bpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpa_pkg::ST_CLEAR;
      hint      <= '0;
      count     <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      hint     <= hint_next;
      count    <= count_next;
      clr_addr <= clr_addr_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_addr  <= scan_addr_next;
    cur_word   <= cur_word_next;
    cur_bit    <= cur_bit_next;
    cur_page   <= cur_page_next;
    cur_req    <= cur_req_next;
    res_status <= res_status_next;
    res_index  <= res_index_next;
    res_free   <= res_free_next;
    if (out_load) begin
      status       <= res_status;
      result_index <= res_index;
      is_free      <= res_free;
      pages_in_use <= count[bpa_pkg::USED_W-1:0];
    end
  end

endmodule
